// File: rtl/imu_serial_frame_parser_top_defines.svh
// Assertion macros used by the checker file of the frame parser.
// Both macros sample on the rising edge of the block clock.
`ifndef IMU_SERIAL_FRAME_PARSER_TOP_DEFINES_SVH
`define IMU_SERIAL_FRAME_PARSER_TOP_DEFINES_SVH

// Property that is ignored while reset is high.
`define ISFP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property that is also checked during reset.
`define ISFP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/isfp_pkg.sv
`default_nettype none

package isfp_pkg;

   // Frame layout.
   localparam int unsigned FRAME_LEN = 11;
   localparam int unsigned WIN_DEPTH = FRAME_LEN - 1;
   localparam int unsigned COUNT_W   = 4;
   localparam int unsigned NUM_AXES  = 3;
   localparam int unsigned RAW_W     = 16;

   localparam logic [7:0] SYNC_BYTE  = 8'h55;
   localparam logic [7:0] TYPE_ACCEL = 8'h51;
   localparam logic [7:0] TYPE_RATE  = 8'h52;
   localparam logic [7:0] TYPE_ANGLE = 8'h53;

   // Result widths.
   localparam int unsigned ACCEL_W   = 25;
   localparam int unsigned RATE_W    = 23;
   localparam int unsigned ANGLE_W   = 19;
   localparam int unsigned MAG_OUT_W = 24;

   localparam int unsigned QUEUE_DEPTH = 4;

   // Acceleration: round(mag * 196133 / 625) = mag * 313 + floor((mag * 508 + 312) / 625).
   localparam int unsigned ACC_T_W       = 24;
   localparam int unsigned ACCEL_INT     = 313;
   localparam int unsigned ACCEL_FRAC    = 508;
   localparam int unsigned ACCEL_ROUND   = 312;
   localparam int unsigned RECIP_W       = 25;
   localparam logic [RECIP_W-1:0] DIV625_RECIP = 25'd27487791;
   localparam int unsigned DIV625_SHIFT  = 34;

   // Rate and angle: (mag * K + 2^31) >> 32, with K split as K_HI * 2^20 + K_LO.
   localparam int unsigned K_SPLIT = 20;
   localparam int unsigned K_HI_W  = 19;
   localparam int unsigned K_LO_W  = 20;
   localparam logic [K_HI_W-1:0] RATE_K_HI  = 19'd285954;
   localparam logic [K_LO_W-1:0] RATE_K_LO  = 20'd780819;
   localparam logic [K_HI_W-1:0] ANGLE_K_HI = 19'd25735;
   localparam logic [K_LO_W-1:0] ANGLE_K_LO = 20'd972049;
   localparam int unsigned P_HI_W = RAW_W + K_HI_W;
   localparam int unsigned P_LO_W = RAW_W + K_LO_W;
   localparam int unsigned WIDE_W = 56;
   localparam int unsigned Q32_SHIFT = 32;

   typedef enum logic [1:0] {
      GRP_ACCEL,
      GRP_RATE,
      GRP_ANGLE
   } group_type;

   typedef struct packed {
      group_type                          group;
      logic [NUM_AXES-1:0][RAW_W-1:0]     raw;
   } frame_type;

endpackage

`default_nettype wire

// File: rtl/isfp_if.sv
`default_nettype none

interface isfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface isfp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [isfp_pkg::ACCEL_W-1:0]  accel_x;
   logic signed [isfp_pkg::ACCEL_W-1:0]  accel_y;
   logic signed [isfp_pkg::ACCEL_W-1:0]  accel_z;
   logic signed [isfp_pkg::RATE_W-1:0]   rate_x;
   logic signed [isfp_pkg::RATE_W-1:0]   rate_y;
   logic signed [isfp_pkg::RATE_W-1:0]   rate_z;
   logic signed [isfp_pkg::ANGLE_W-1:0]  roll_angle;
   logic signed [isfp_pkg::ANGLE_W-1:0]  pitch_angle;
   logic signed [isfp_pkg::ANGLE_W-1:0]  yaw_angle;

   modport source (
      output valid, output accel_x, output accel_y, output accel_z,
      output rate_x, output rate_y, output rate_z,
      output roll_angle, output pitch_angle, output yaw_angle,
      input ready
   );
   modport sink (
      input valid, input accel_x, input accel_y, input accel_z,
      input rate_x, input rate_y, input rate_z,
      input roll_angle, input pitch_angle, input yaw_angle,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/isfp_front.sv
`default_nettype none

module isfp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_take,
   input  logic [7:0]          rx_byte,
   output logic                push,
   output isfp_pkg::frame_type push_data
);

   logic [7:0]                       win_ff [isfp_pkg::WIN_DEPTH];
   logic [7:0]                       win_in [isfp_pkg::WIN_DEPTH];
   logic [isfp_pkg::COUNT_W-1:0]     count_ff;
   logic [isfp_pkg::COUNT_W-1:0]     count_in;
   logic [7:0]                       sum_ff;
   logic [7:0]                       sum_in;
   logic                             window_full;
   logic                             frame_ok;
   logic                             type_known;

   // The running sum always equals the low byte of the sum of the held bytes.
   always_comb begin
      window_full = (count_ff == isfp_pkg::COUNT_W'(isfp_pkg::WIN_DEPTH));
      frame_ok    = window_full && (win_ff[0] == isfp_pkg::SYNC_BYTE) && (sum_ff == rx_byte);
      type_known  = win_ff[1] inside {isfp_pkg::TYPE_ACCEL, isfp_pkg::TYPE_RATE,
                                      isfp_pkg::TYPE_ANGLE};

      case (win_ff[1])
         isfp_pkg::TYPE_RATE: begin
            push_data.group = isfp_pkg::GRP_RATE;
         end
         isfp_pkg::TYPE_ANGLE: begin
            push_data.group = isfp_pkg::GRP_ANGLE;
         end
         default: begin
            push_data.group = isfp_pkg::GRP_ACCEL;
         end
      endcase
      for (int k = 0; k < isfp_pkg::NUM_AXES; k++) begin
         push_data.raw[k] = {win_ff[3 + 2 * k], win_ff[2 + 2 * k]};
      end

      win_in   = win_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      push     = 1'b0;

      if (byte_take) begin
         if (!window_full) begin
            for (int i = 0; i < isfp_pkg::WIN_DEPTH; i++) begin
               if (isfp_pkg::COUNT_W'(i) == count_ff) begin
                  win_in[i] = rx_byte;
               end
            end
            count_in = count_ff + isfp_pkg::COUNT_W'(1);
            sum_in   = sum_ff + rx_byte;
         end else if (frame_ok) begin
            count_in = '0;
            sum_in   = '0;
            push     = type_known;
         end else begin
            for (int i = 0; i < isfp_pkg::WIN_DEPTH - 1; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            win_in[isfp_pkg::WIN_DEPTH - 1] = rx_byte;
            sum_in = sum_ff - win_ff[0] + rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

`default_nettype wire

// File: rtl/isfp_queue.sv
`default_nettype none

module isfp_queue #(
   parameter int unsigned DEPTH = isfp_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  isfp_pkg::frame_type push_data,
   output logic                full,
   input  logic                pop,
   output isfp_pkg::frame_type pop_data,
   output logic                empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   isfp_pkg::frame_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_in;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 do_push;
   logic                 do_pop;

   always_comb begin
      full     = (count_ff == CNT_W'(DEPTH));
      empty    = (count_ff == '0);
      do_push  = push && !full;
      do_pop   = pop && !empty;
      pop_data = mem_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/isfp_scale.sv
`default_nettype none

module isfp_scale (
   input  logic                                  clock,
   input  logic                                  reset,
   output logic                                  pop,
   input  isfp_pkg::frame_type                   pop_data,
   input  logic                                  empty,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic signed [isfp_pkg::ACCEL_W-1:0]   accel [isfp_pkg::NUM_AXES],
   output logic signed [isfp_pkg::RATE_W-1:0]    rate  [isfp_pkg::NUM_AXES],
   output logic signed [isfp_pkg::ANGLE_W-1:0]   angle [isfp_pkg::NUM_AXES]
);

   localparam int unsigned N    = isfp_pkg::NUM_AXES;
   localparam int unsigned MW   = isfp_pkg::RAW_W;
   localparam int unsigned TW   = isfp_pkg::ACC_T_W;
   localparam int unsigned OW   = isfp_pkg::MAG_OUT_W;
   localparam int unsigned PW   = TW + isfp_pkg::RECIP_W;
   localparam int unsigned WW   = isfp_pkg::WIDE_W;
   localparam int unsigned AW   = isfp_pkg::ACCEL_W;

   logic                                adv;
   logic                                emit;

   // Stage 1: sign and magnitude of each raw value.
   logic                                s1_valid_ff;
   isfp_pkg::group_type                 s1_group_ff;
   logic [N-1:0]                        s1_neg_ff;
   logic [N-1:0]                        s1_neg_in;
   logic [MW-1:0]                       s1_mag_ff [N];
   logic [MW-1:0]                       s1_mag_in [N];

   // Stage 2: constant products.
   logic                                s2_valid_ff;
   isfp_pkg::group_type                 s2_group_ff;
   logic [N-1:0]                        s2_neg_ff;
   logic [isfp_pkg::K_HI_W-1:0]         k_hi;
   logic [isfp_pkg::K_LO_W-1:0]         k_lo;
   logic [isfp_pkg::P_HI_W-1:0]         s2_phi_ff [N];
   logic [isfp_pkg::P_HI_W-1:0]         s2_phi_in [N];
   logic [isfp_pkg::P_LO_W-1:0]         s2_plo_ff [N];
   logic [isfp_pkg::P_LO_W-1:0]         s2_plo_in [N];
   logic [TW-1:0]                       s2_t_ff [N];
   logic [TW-1:0]                       s2_t_in [N];
   logic [TW-1:0]                       s2_base_ff [N];
   logic [TW-1:0]                       s2_base_in [N];

   // Stage 3: rounded magnitudes.
   logic                                s3_valid_ff;
   isfp_pkg::group_type                 s3_group_ff;
   logic [N-1:0]                        s3_neg_ff;
   logic [OW-1:0]                       s3_mag_ff [N];
   logic [OW-1:0]                       s3_mag_in [N];
   logic [PW-1:0]                       acc_prod [N];
   logic [WW-1:0]                       wide_sum [N];

   // Final stage: signed values and the partial sample.
   logic signed [AW-1:0]                value [N];
   logic [N-1:0]                        seen_ff;
   logic [N-1:0]                        seen_next;
   logic signed [AW-1:0]                held_accel_ff [N];
   logic signed [isfp_pkg::RATE_W-1:0]  held_rate_ff [N];
   logic signed [isfp_pkg::ANGLE_W-1:0] held_angle_ff [N];
   logic signed [AW-1:0]                nxt_accel [N];
   logic signed [isfp_pkg::RATE_W-1:0]  nxt_rate [N];
   logic signed [isfp_pkg::ANGLE_W-1:0] nxt_angle [N];
   logic                                rsp_valid_ff;

   always_comb begin
      adv = !rsp_valid_ff || rsp_ready;
      pop = adv && !empty;

      for (int k = 0; k < N; k++) begin
         s1_neg_in[k] = pop_data.raw[k][MW-1];
         s1_mag_in[k] = s1_neg_in[k] ? (~pop_data.raw[k] + MW'(1)) : pop_data.raw[k];
      end

      if (s1_group_ff == isfp_pkg::GRP_ANGLE) begin
         k_hi = isfp_pkg::ANGLE_K_HI;
         k_lo = isfp_pkg::ANGLE_K_LO;
      end else begin
         k_hi = isfp_pkg::RATE_K_HI;
         k_lo = isfp_pkg::RATE_K_LO;
      end
      for (int k = 0; k < N; k++) begin
         s2_phi_in[k]  = isfp_pkg::P_HI_W'(s1_mag_ff[k]) * isfp_pkg::P_HI_W'(k_hi);
         s2_plo_in[k]  = isfp_pkg::P_LO_W'(s1_mag_ff[k]) * isfp_pkg::P_LO_W'(k_lo);
         s2_t_in[k]    = TW'(s1_mag_ff[k]) * TW'(isfp_pkg::ACCEL_FRAC)
                         + TW'(isfp_pkg::ACCEL_ROUND);
         s2_base_in[k] = TW'(s1_mag_ff[k]) * TW'(isfp_pkg::ACCEL_INT);
      end

      for (int k = 0; k < N; k++) begin
         acc_prod[k] = PW'(s2_t_ff[k]) * PW'(isfp_pkg::DIV625_RECIP);
         wide_sum[k] = WW'({s2_phi_ff[k], isfp_pkg::K_SPLIT'(0)}) + WW'(s2_plo_ff[k])
                       + (WW'(1) << (isfp_pkg::Q32_SHIFT - 1));
         if (s2_group_ff == isfp_pkg::GRP_ACCEL) begin
            s3_mag_in[k] = OW'(s2_base_ff[k]) + OW'(acc_prod[k] >> isfp_pkg::DIV625_SHIFT);
         end else begin
            s3_mag_in[k] = OW'(wide_sum[k] >> isfp_pkg::Q32_SHIFT);
         end
      end

      for (int k = 0; k < N; k++) begin
         value[k]     = s3_neg_ff[k] ? -$signed({1'b0, s3_mag_ff[k]})
                                     : $signed({1'b0, s3_mag_ff[k]});
         nxt_accel[k] = held_accel_ff[k];
         nxt_rate[k]  = held_rate_ff[k];
         nxt_angle[k] = held_angle_ff[k];
      end
      seen_next = seen_ff;
      case (s3_group_ff)
         isfp_pkg::GRP_ACCEL: begin
            seen_next = seen_ff | N'(1);
            for (int k = 0; k < N; k++) begin
               nxt_accel[k] = value[k];
            end
         end
         isfp_pkg::GRP_RATE: begin
            seen_next = seen_ff | N'(2);
            for (int k = 0; k < N; k++) begin
               nxt_rate[k] = value[k][isfp_pkg::RATE_W-1:0];
            end
         end
         isfp_pkg::GRP_ANGLE: begin
            seen_next = seen_ff | N'(4);
            for (int k = 0; k < N; k++) begin
               nxt_angle[k] = value[k][isfp_pkg::ANGLE_W-1:0];
            end
         end
         default: begin
            seen_next = seen_ff;
         end
      endcase
      emit = s3_valid_ff && adv && (seen_next == '1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            s1_valid_ff <= pop;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            if (s3_valid_ff) begin
               seen_ff <= emit ? '0 : seen_next;
            end
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Every group is rewritten before a sample goes out, so the held values need no reset.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_group_ff <= pop_data.group;
         s1_neg_ff   <= s1_neg_in;
         s1_mag_ff   <= s1_mag_in;
         s2_group_ff <= s1_group_ff;
         s2_neg_ff   <= s1_neg_ff;
         s2_phi_ff   <= s2_phi_in;
         s2_plo_ff   <= s2_plo_in;
         s2_t_ff     <= s2_t_in;
         s2_base_ff  <= s2_base_in;
         s3_group_ff <= s2_group_ff;
         s3_neg_ff   <= s2_neg_ff;
         s3_mag_ff   <= s3_mag_in;
         if (s3_valid_ff) begin
            held_accel_ff <= nxt_accel;
            held_rate_ff  <= nxt_rate;
            held_angle_ff <= nxt_angle;
         end
      end
      if (emit) begin
         accel <= nxt_accel;
         rate  <= nxt_rate;
         angle <= nxt_angle;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: rtl/imu_serial_frame_parser_top.sv
// Serial IMU frame parser. Each req_ch transaction carries one received byte; the block
// hunts for eleven-byte frames that start with 0x55 and end in the low byte of the sum of
// the first ten, and decodes acceleration (type 0x51), angular rate (0x52) and angle
// (0x53) frames into Q16.16 values in m/s^2, rad/s and rad, rounded to nearest. After all
// three groups have arrived, one rsp_ch transaction delivers the nine values and the
// collection starts over; a group that arrives twice before that simply replaces its
// values, and frames of any other type are consumed silently. The block takes one byte
// per clock cycle while req_ch.ready is high. Frames go from the queue through the
// three-stage scaling pipeline and then the output register. req_ch.ready only drops when
// the frame queue between the byte front end and the scaling pipeline is full, which can
// happen only while a finished sample waits on rsp_ch.
`default_nettype none

module imu_serial_frame_parser_top #(
   parameter int unsigned QUEUE_DEPTH = isfp_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   isfp_req_if.sink    req_ch,
   isfp_rsp_if.source  rsp_ch
);

   logic                                 byte_take;
   logic                                 push;
   isfp_pkg::frame_type                  push_data;
   logic                                 queue_full;
   logic                                 pop;
   isfp_pkg::frame_type                  pop_data;
   logic                                 queue_empty;
   logic signed [isfp_pkg::ACCEL_W-1:0]  accel [isfp_pkg::NUM_AXES];
   logic signed [isfp_pkg::RATE_W-1:0]   rate  [isfp_pkg::NUM_AXES];
   logic signed [isfp_pkg::ANGLE_W-1:0]  angle [isfp_pkg::NUM_AXES];

   // A byte is taken whenever the queue has room, since a byte can complete a frame.
   assign req_ch.ready = !queue_full;
   assign byte_take    = req_ch.valid && !queue_full;

   // The front end keeps the sliding byte window and pushes each valid frame
   // of a known type into the queue.
   isfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .byte_take (byte_take),
      .rx_byte   (req_ch.rx_byte),
      .push      (push),
      .push_data (push_data)
   );

   isfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   // The back end scales the raw values, collects the three groups and holds
   // the finished sample in its output register.
   isfp_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .accel     (accel),
      .rate      (rate),
      .angle     (angle)
   );

   assign rsp_ch.accel_x     = accel[0];
   assign rsp_ch.accel_y     = accel[1];
   assign rsp_ch.accel_z     = accel[2];
   assign rsp_ch.rate_x      = rate[0];
   assign rsp_ch.rate_y      = rate[1];
   assign rsp_ch.rate_z      = rate[2];
   assign rsp_ch.roll_angle  = angle[0];
   assign rsp_ch.pitch_angle = angle[1];
   assign rsp_ch.yaw_angle   = angle[2];

endmodule

`default_nettype wire

// File: rtl/isfp_checker.sv
`default_nettype none
`include "imu_serial_frame_parser_top_defines.svh"

module isfp_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [isfp_pkg::ACCEL_W-1:0]   accel_x,
   input logic signed [isfp_pkg::RATE_W-1:0]    rate_x,
   input logic signed [isfp_pkg::ANGLE_W-1:0]   roll_angle
);

   logic                                                               rsp_stall;
   logic [isfp_pkg::ACCEL_W+isfp_pkg::RATE_W+isfp_pkg::ANGLE_W-1:0]    rsp_view;
   logic                                                               accel_ok;
   logic                                                               rate_ok;
   logic                                                               angle_ok;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_view  = {accel_x, rate_x, roll_angle};
   assign accel_ok  = (accel_x >= -25'sd10283018) && (accel_x <= 25'sd10283018);
   assign rate_ok   = (rate_x >= -23'sd2287638) && (rate_x <= 23'sd2287638);
   assign angle_ok  = (roll_angle >= -19'sd205887) && (roll_angle <= 19'sd205887);

   `ISFP_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid, "rsp valid after reset")
   `ISFP_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_view), "stalled sample changed")
   `ISFP_ASSERT(a_accel_range, rsp_valid |-> accel_ok, "accel out of range")
   `ISFP_ASSERT(a_rate_angle_range, rsp_valid |-> rate_ok && angle_ok, "rate or angle out of range")
   `ISFP_ASSERT(a_req_stall, !req_ready |-> $past(rsp_stall), "input stalled without output stall")

endmodule

bind imu_serial_frame_parser_top isfp_checker u_isfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .accel_x    (rsp_ch.accel_x),
   .rate_x     (rsp_ch.rate_x),
   .roll_angle (rsp_ch.roll_angle)
);

`default_nettype wire

// File: tb/imu_frame_check_pkg.sv
`timescale 1ns / 1ps

package imu_frame_check_pkg;
   import isfp_pkg::*;

   // Acceleration is raw * 3138128 / 10000; rate and angle are raw * K / 2^32.
   localparam longint unsigned ACCEL_MUL = 64'd3138128;
   localparam longint unsigned ACCEL_DIV = 64'd10000;
   localparam longint unsigned RATE_MUL  = 64'd299845282323;
   localparam longint unsigned ANGLE_MUL = 64'd26986075409;
   localparam longint unsigned Q32_HALF  = 64'h8000_0000;

   typedef struct packed {
      logic signed [ACCEL_W-1:0] accel_x;
      logic signed [ACCEL_W-1:0] accel_y;
      logic signed [ACCEL_W-1:0] accel_z;
      logic signed [RATE_W-1:0]  rate_x;
      logic signed [RATE_W-1:0]  rate_y;
      logic signed [RATE_W-1:0]  rate_z;
      logic signed [ANGLE_W-1:0] roll_angle;
      logic signed [ANGLE_W-1:0] pitch_angle;
      logic signed [ANGLE_W-1:0] yaw_angle;
   } imu_sample_type;

   // Scales one signed raw reading; the rounding works on the magnitude so that
   // halves go away from zero.
   function automatic int scaled_value(group_type grp, logic [RAW_W-1:0] raw);
      longint unsigned mag;
      longint unsigned q;
      mag = raw[RAW_W-1] ? 64'(17'h1_0000 - 17'(raw)) : 64'(raw);
      case (grp)
         GRP_ACCEL: q = (mag * ACCEL_MUL + ACCEL_DIV / 2) / ACCEL_DIV;
         GRP_RATE:  q = (mag * RATE_MUL + Q32_HALF) >> Q32_SHIFT;
         default:   q = (mag * ANGLE_MUL + Q32_HALF) >> Q32_SHIFT;
      endcase
      return raw[RAW_W-1] ? -int'(q) : int'(q);
   endfunction

   class imu_sample_checker;
      logic [7:0]     window[FRAME_LEN];
      int unsigned    window_fill;
      int             held[3*NUM_AXES];
      logic [2:0]     groups_seen;
      imu_sample_type expected_samples[$];
      int unsigned    mismatches;

      function new();
         window_fill = 0;
         groups_seen = '0;
         mismatches  = 0;
         foreach (held[i]) held[i] = 0;
      endfunction

      function int unsigned pending();
         return expected_samples.size();
      endfunction

      // Advances the frame decoder by one accepted byte and queues the sample it completes.
      function void note_byte(logic [7:0] rx);
         logic [7:0]     sum;
         group_type      grp;
         bit             known;
         imu_sample_type s;
         if (window_fill < FRAME_LEN) begin
            window[window_fill] = rx;
            window_fill++;
         end
         if (window_fill < FRAME_LEN) return;
         sum = '0;
         for (int i = 0; i < FRAME_LEN - 1; i++) sum += window[i];
         if (window[0] != SYNC_BYTE || sum != window[FRAME_LEN-1]) begin
            for (int i = 0; i < FRAME_LEN - 1; i++) window[i] = window[i+1];
            window_fill = FRAME_LEN - 1;
            return;
         end
         window_fill = 0;
         grp   = GRP_ACCEL;
         known = 1'b1;
         case (window[1])
            TYPE_ACCEL: grp = GRP_ACCEL;
            TYPE_RATE:  grp = GRP_RATE;
            TYPE_ANGLE: grp = GRP_ANGLE;
            default:    known = 1'b0;
         endcase
         if (known) begin
            for (int a = 0; a < NUM_AXES; a++)
               held[int'(grp) * NUM_AXES + a] =
                  scaled_value(grp, {window[3 + 2*a], window[2 + 2*a]});
            groups_seen[int'(grp)] = 1'b1;
         end
         if (groups_seen != 3'b111) return;
         s.accel_x     = ACCEL_W'(held[0]);
         s.accel_y     = ACCEL_W'(held[1]);
         s.accel_z     = ACCEL_W'(held[2]);
         s.rate_x      = RATE_W'(held[3]);
         s.rate_y      = RATE_W'(held[4]);
         s.rate_z      = RATE_W'(held[5]);
         s.roll_angle  = ANGLE_W'(held[6]);
         s.pitch_angle = ANGLE_W'(held[7]);
         s.yaw_angle   = ANGLE_W'(held[8]);
         expected_samples = {expected_samples, s};
         foreach (held[i]) held[i] = 0;
         groups_seen = '0;
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_sample(imu_sample_type got);
         imu_sample_type want;
         if (expected_samples.size() == 0) begin
            mismatches++;
            $display("%0t: sample with none expected, expected nothing, actual %p", $time, got);
            return;
         end
         want = expected_samples[0];
         expected_samples.delete(0);
         compare_field("accel_x", want.accel_x, got.accel_x);
         compare_field("accel_y", want.accel_y, got.accel_y);
         compare_field("accel_z", want.accel_z, got.accel_z);
         compare_field("rate_x", want.rate_x, got.rate_x);
         compare_field("rate_y", want.rate_y, got.rate_y);
         compare_field("rate_z", want.rate_z, got.rate_z);
         compare_field("roll_angle", want.roll_angle, got.roll_angle);
         compare_field("pitch_angle", want.pitch_angle, got.pitch_angle);
         compare_field("yaw_angle", want.yaw_angle, got.yaw_angle);
      endfunction
   endclass

endpackage

// File: tb/imu_serial_frame_parser_top_tb.sv
`timescale 1ns / 1ps

module imu_serial_frame_parser_top_tb;
   import isfp_pkg::*;
   import imu_frame_check_pkg::*;

   // Cycles without any transaction on either channel before the run is declared hung.
   localparam int unsigned STALL_LIMIT   = 2000;
   // Extra cycles to watch for unexpected samples once all expected ones are out.
   localparam int unsigned DRAIN_CYCLES  = 16;
   localparam int unsigned RESET_CYCLES  = 11;
   // Each random phase runs until both of these are reached.
   localparam int unsigned PHASE_BYTES   = 480;
   localparam int unsigned PHASE_SEQS    = 12;
   // Frame types right next to the decoded ones.
   localparam logic [7:0]  TYPE_BELOW    = TYPE_ACCEL - 8'd1;
   localparam logic [7:0]  TYPE_ABOVE    = TYPE_ANGLE + 8'd1;

   logic clock = 1'b0;
   logic reset;

   isfp_req_if req_if ();
   isfp_rsp_if rsp_if ();

   imu_serial_frame_parser_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   imu_sample_checker samples = new();

   // Bytes still to be offered on the request channel, oldest first.
   logic [7:0]  byte_stream[$];
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned stall_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Raw readings lean toward full scale and the values around zero, where the sign
   // handling and the rounding are most likely to go wrong.
   function automatic logic [15:0] rand_raw();
      case ($urandom_range(9, 0))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'($urandom_range(2, 0)) - 16'd1;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] group_code(int unsigned g);
      case (g)
         0:       return TYPE_ACCEL;
         1:       return TYPE_RATE;
         default: return TYPE_ANGLE;
      endcase
   endfunction

   function automatic logic [7:0] unknown_code();
      logic [7:0] code;
      do
         code = 8'($urandom);
      while (code == TYPE_ACCEL || code == TYPE_RATE || code == TYPE_ANGLE);
      return code;
   endfunction

   // Appends one well-formed frame: sync, type, three little-endian readings, two
   // filler bytes and the checksum over the first ten bytes.
   function automatic void push_frame(logic [7:0] kind, logic [15:0] v0, v1, v2);
      logic [7:0] frame[FRAME_LEN];
      logic [7:0] sum;
      frame[0] = SYNC_BYTE;
      frame[1] = kind;
      {frame[3], frame[2]} = v0;
      {frame[5], frame[4]} = v1;
      {frame[7], frame[6]} = v2;
      frame[8] = 8'($urandom);
      frame[9] = 8'($urandom);
      sum = '0;
      for (int i = 0; i < FRAME_LEN - 1; i++) sum += frame[i];
      frame[FRAME_LEN-1] = sum;
      foreach (frame[i]) byte_stream = {byte_stream, frame[i]};
   endfunction

   // A frame with one flipped bit in the sync byte, the checksum or the body. Any
   // single-bit change breaks either the sync match or the checksum.
   function automatic void push_broken_frame();
      int unsigned spot;
      push_frame(group_code($urandom_range(2, 0)), rand_raw(), rand_raw(), rand_raw());
      case ($urandom_range(2, 0))
         0:       spot = 0;
         1:       spot = FRAME_LEN - 1;
         default: spot = $urandom_range(FRAME_LEN - 2, 1);
      endcase
      byte_stream[byte_stream.size() - FRAME_LEN + spot] ^= 8'(1 << $urandom_range(7, 0));
   endfunction

   // Line noise, with plenty of stray sync bytes so the window keeps sliding onto
   // false frame starts.
   function automatic void push_noise(int unsigned count);
      logic [7:0] noise;
      repeat (count) begin
         noise = ($urandom_range(3, 0) == 0) ? SYNC_BYTE : 8'($urandom);
         byte_stream = {byte_stream, noise};
      end
   endfunction

   // The three groups of one sample in a random order. Now and then a group is
   // preceded by noise, a damaged frame, a frame of another type, or an earlier copy
   // of itself that the later one must replace.
   function automatic void push_sample_sequence();
      int unsigned first;
      int unsigned stride;
      int unsigned g;
      first  = $urandom_range(2, 0);
      stride = $urandom_range(2, 1);
      for (int k = 0; k < NUM_AXES; k++) begin
         g = (first + k * stride) % 3;
         case ($urandom_range(19, 0))
            0:       push_noise($urandom_range(5, 1));
            1:       push_broken_frame();
            2:       push_frame(unknown_code(), rand_raw(), rand_raw(), rand_raw());
            3:       push_frame(group_code(g), rand_raw(), rand_raw(), rand_raw());
            default: ;
         endcase
         push_frame(group_code(g), rand_raw(), rand_raw(), rand_raw());
      end
   endfunction

   function automatic void fill_random_phase();
      int unsigned seqs;
      seqs = 0;
      while (byte_stream.size() < PHASE_BYTES || seqs < PHASE_SEQS) begin
         if ($urandom_range(9, 0) == 0) push_noise($urandom_range(6, 1));
         push_sample_sequence();
         seqs++;
      end
   endfunction

   function automatic void push_directed();
      // Full-scale readings of both signs in every group, plus the smallest steps.
      push_frame(TYPE_ACCEL, 16'h7FFF, 16'h8000, 16'h0000);
      push_frame(TYPE_RATE, 16'h8000, 16'h7FFF, 16'h0001);
      push_frame(TYPE_ANGLE, 16'h7FFF, 16'hFFFF, 16'h8000);
      // Valid frames of other types are swallowed and must not disturb the held values.
      push_frame(TYPE_BELOW, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      push_frame(TYPE_ABOVE, 16'h8000, 16'h8000, 16'h8000);
      push_frame(8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_frame(8'hFF, 16'h0000, 16'h0000, 16'h0000);
      // Reverse order, and the rate group arrives twice: only the later copy counts.
      push_frame(TYPE_ANGLE, 16'h0001, 16'h0000, 16'hFFFF);
      push_frame(TYPE_RATE, 16'h1234, 16'h4321, 16'h7FFF);
      push_frame(TYPE_RATE, 16'hFFFF, 16'h0001, 16'h8000);
      // A frame with a wrong sync byte, then one with a wrong checksum. Each rejection
      // drops only the oldest byte, so the decoder rescans what follows.
      push_frame(TYPE_ACCEL, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      byte_stream[byte_stream.size() - FRAME_LEN] = 8'hAA;
      push_frame(TYPE_ACCEL, 16'h8000, 16'h8000, 16'h8000);
      byte_stream[byte_stream.size() - 1] ^= 8'h01;
      // Stray sync bytes right ahead of a real frame: the window must slide onto it.
      repeat (3) byte_stream = {byte_stream, SYNC_BYTE};
      push_frame(TYPE_ACCEL, 16'h8000, 16'h7FFF, 16'hFFFF);
      // One more sample that mixes alternating bit patterns with all-zero and all-one raw fields.
      push_frame(TYPE_RATE, 16'h0000, 16'hFFFF, 16'h5555);
      push_frame(TYPE_ANGLE, 16'hAAAA, 16'h5555, 16'h0000);
      push_frame(TYPE_ACCEL, 16'h5555, 16'hAAAA, 16'hFFFF);
   endfunction

   // Offers every queued byte as a request transaction. Before each one the sender
   // may sit idle for a random number of cycles. The byte is handed to the checker
   // at the edge where valid and ready are both high.
   task automatic send_stream();
      logic [7:0] rx;
      while (byte_stream.size() != 0) begin
         rx = byte_stream[0];
         byte_stream.delete(0);
         while ($urandom_range(99, 0) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
         req_if.valid   <= 1'b1;
         req_if.rx_byte <= rx;
         @(posedge clock);
         while (!req_if.ready) @(posedge clock);
         samples.note_byte(rx);
      end
   endtask

   // Response side: at each edge, a transaction seen with valid and ready high is
   // checked against the oldest expected sample, then ready is redrawn for the
   // next cycle.
   initial begin
      imu_sample_type got;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.accel_x     = rsp_if.accel_x;
            got.accel_y     = rsp_if.accel_y;
            got.accel_z     = rsp_if.accel_z;
            got.rate_x      = rsp_if.rate_x;
            got.rate_y      = rsp_if.rate_y;
            got.rate_z      = rsp_if.rate_z;
            got.roll_angle  = rsp_if.roll_angle;
            got.pitch_angle = rsp_if.pitch_angle;
            got.yaw_angle   = rsp_if.yaw_angle;
            samples.check_sample(got);
         end
         rsp_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // Watchdog: any transaction on either channel counts as progress.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         stall_cycles = 0;
      else
         stall_cycles = stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Main sequence: reset, the directed frames, then three random phases that swap
   // which side does most of the idling and finally run both sides flat out.
   initial begin
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.rx_byte <= '0;
      send_idle_pct = 14;
      recv_idle_pct = 82;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      push_directed();
      fill_random_phase();
      send_stream();

      send_idle_pct = 82;
      recv_idle_pct = 14;
      fill_random_phase();
      send_stream();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      fill_random_phase();
      send_stream();
      req_if.valid <= 1'b0;

      // Let every expected sample come out, then watch a little longer for extras.
      while (samples.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (samples.mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
